// ----- sv/gf16cm_pkg.sv -----
// gf16cm_pkg: shared types, constants and field arithmetic helpers for the
// gf(2^16) constant multiply-accumulate block. no dependencies.
`timescale 1ns / 1ps

package gf16cm_pkg;

  // field and table geometry
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TBL_DEPTH  = 256;
  localparam int unsigned TBL_ADDR_W = 8;

  localparam logic [WORD_W-1:0] COEFF_RESET = 16'h0001;
  localparam logic [WORD_W-1:0] POLY_RESET  = 16'h100B;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_COEFFICIENT = 1'b0,
    REG_POLY_LOW    = 1'b1
  } cfg_reg_e;

  // table builder sequencer
  typedef enum logic [1:0] {
    BLD_PREP,
    BLD_FILL,
    BLD_RUN
  } bld_state_e;

  // table write transaction from the builder to both rams
  typedef struct packed {
    logic                  we;
    logic [TBL_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]     lo_data;
    logic [WORD_W-1:0]     hi_data;
  } tbl_wr_t;

  // multiply a by x, reduced by x^16 + poly
  function automatic logic [WORD_W-1:0] mul_x(input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] poly);
    logic [WORD_W-1:0] r;
    r = {a[WORD_W-2:0], 1'b0};
    if (a[WORD_W-1]) begin
      r = r ^ poly;
    end
    return r;
  endfunction

  // a times x^8, eight shift-and-reduce steps
  function automatic logic [WORD_W-1:0] mul_x8(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] poly);
    logic [WORD_W-1:0] run;
    run = a;
    for (int i = 0; i < BYTE_W; i++) begin
      run = mul_x(run, poly);
    end
    return run;
  endfunction

  // carry-less product of a word and a byte, reduced by x^16 + poly
  function automatic logic [WORD_W-1:0] mul_byte(input logic [WORD_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [WORD_W-1:0] poly);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] run;
    acc = '0;
    run = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ run;
      end
      run = mul_x(run, poly);
    end
    return acc;
  endfunction

endpackage

// ----- sv/gf16cm_ram.sv -----
// gf16cm_ram: generic single-write, single-read ram with registered read.
// no dependencies.
`timescale 1ns / 1ps

module gf16cm_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/gf16cm_table_build.sv -----
// gf16cm_table_build: configuration registers and the sequencer that fills
// the two byte-product tables. depends on gf16cm_pkg.
`timescale 1ns / 1ps

module gf16cm_table_build (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  gf16cm_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [gf16cm_pkg::WORD_W-1:0] cfg_wdata_i,
  output gf16cm_pkg::tbl_wr_t           tbl_wr_o,
  output logic                          ready_o
);

  import gf16cm_pkg::*;

  bld_state_e            state_q, state_d;
  logic [WORD_W-1:0]     coeff_q, coeff_d;
  logic [WORD_W-1:0]     poly_q, poly_d;
  logic [WORD_W-1:0]     coeff_x8_q, coeff_x8_d;
  logic [TBL_ADDR_W-1:0] cnt_q, cnt_d;

  // register writes
  always_comb begin
    coeff_d = coeff_q;
    poly_d  = poly_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEFFICIENT: coeff_d = cfg_wdata_i;
        REG_POLY_LOW:    poly_d  = cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // next state: any register write restarts the fill
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = BLD_PREP;
    end else begin
      case (state_q)
        BLD_PREP: state_d = BLD_FILL;
        BLD_FILL: begin
          if (cnt_q == TBL_ADDR_W'(TBL_DEPTH - 1)) begin
            state_d = BLD_RUN;
          end
        end
        BLD_RUN:  state_d = BLD_RUN;
        default:  state_d = BLD_PREP;
      endcase
    end
  end

  // fill counter and the coefficient pre-shifted for the high table
  always_comb begin
    cnt_d      = cnt_q;
    coeff_x8_d = coeff_x8_q;
    case (state_q)
      BLD_PREP: begin
        cnt_d      = '0;
        coeff_x8_d = mul_x8(coeff_q, poly_q);
      end
      BLD_FILL: cnt_d = cnt_q + TBL_ADDR_W'(1);
      default:  ;
    endcase
  end

  // outputs
  always_comb begin
    tbl_wr_o.we      = (state_q == BLD_FILL);
    tbl_wr_o.addr    = cnt_q;
    tbl_wr_o.lo_data = mul_byte(coeff_q, cnt_q, poly_q);
    tbl_wr_o.hi_data = mul_byte(coeff_x8_q, cnt_q, poly_q);
    ready_o          = (state_q == BLD_RUN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BLD_PREP;
      coeff_q    <= COEFF_RESET;
      poly_q     <= POLY_RESET;
      cnt_q      <= '0;
      coeff_x8_q <= '0;
    end else begin
      state_q    <= state_d;
      coeff_q    <= coeff_d;
      poly_q     <= poly_d;
      cnt_q      <= cnt_d;
      coeff_x8_q <= coeff_x8_d;
    end
  end

endmodule

// ----- sv/gf16_const_multiply_accumulate.sv -----
// gf16_const_multiply_accumulate: top level of the gf(2^16) constant
// multiply-accumulate stream block. depends on gf16cm_pkg, gf16cm_ram and
// gf16cm_table_build.
`timescale 1ns / 1ps

// Each input word is multiplied in GF(2^16) by the configured coefficient,
// reduced by x^16 + reduction_poly_low, and in mode 1 XORed with the given
// destination word; tlast passes through. The product is the XOR of two
// lookups, coefficient times the low byte and coefficient times the high
// byte shifted up by eight, held in two 256 x 16 rams. After reset and
// after every register write the tables are refilled (the coefficient is
// pre-shifted first, then one entry of each table is written per cycle),
// with s_axis_tready low throughout. Once filled, the block takes one word
// per cycle unless m_axis_tready stalls the output; a word passes the ram
// read, then the output register, and the ram read port sets that rate.
module gf16_const_multiply_accumulate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  gf16cm_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [gf16cm_pkg::WORD_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // src_word[15:0], dst_word[31:16]
  input  logic                          s_axis_tuser,  // mode
  input  logic                          s_axis_tlast,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // result_word[15:0]
  output logic                          m_axis_tlast
);

  import gf16cm_pkg::*;

  tbl_wr_t           tbl_wr;
  logic              tbl_ready;
  logic              accept;
  logic              advance;
  logic [WORD_W-1:0] src_word;
  logic [WORD_W-1:0] lo_rd, hi_rd;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_mode_q;
  logic [WORD_W-1:0] s1_dst_q;
  logic              s1_last_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q;

  // table builder and configuration registers
  gf16cm_table_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tbl_wr_o   (tbl_wr),
    .ready_o    (tbl_ready)
  );

  assign src_word = s_axis_tdata[WORD_W-1:0];

  // low byte product table
  gf16cm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TBL_DEPTH)
  ) u_lo_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_wr.we),
    .waddr_i(tbl_wr.addr),
    .wdata_i(tbl_wr.lo_data),
    .re_i   (accept),
    .raddr_i(src_word[BYTE_W-1:0]),
    .rdata_o(lo_rd)
  );

  // high byte product table
  gf16cm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TBL_DEPTH)
  ) u_hi_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_wr.we),
    .waddr_i(tbl_wr.addr),
    .wdata_i(tbl_wr.hi_data),
    .re_i   (accept),
    .raddr_i(src_word[WORD_W-1:BYTE_W]),
    .rdata_o(hi_rd)
  );

  // handshake: the lookup stage moves on whenever the output slot frees up
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = tbl_ready && (!s1_valid_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // lookup stage sideband, captured alongside the ram read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= s_axis_tuser;
      s1_dst_q  <= s_axis_tdata[2*WORD_W-1:WORD_W];
      s1_last_q <= s_axis_tlast;
    end
  end

  // output register: combine lookups and optional accumulate
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_word_q <= lo_rd ^ hi_rd ^ (s1_mode_q ? s1_dst_q : '0);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tlast  = out_last_q;

endmodule
